// ===== src/aac_pkg.sv =====
// ----------------------------------------------------------------------------
// aac_pkg: shared definitions for the ARP address cache
// Field widths, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package aac_pkg;

    localparam int AAC_ENTRIES = 16;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int SLOT_W      = 4;
    localparam int TOTAL_W     = 32;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_ADD    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } aac_state_t;

endpackage

// ===== src/arp_address_cache.sv =====
// ----------------------------------------------------------------------------
// arp_address_cache: fully associative IPv4 to MAC address cache
// Each item scans the whole set: one entry is read and compared per cycle.
// Items are taken one at a time, as there is a single read port and a
// single compare unit; a new item is accepted once the sequencer is idle.
// Results cannot be stalled.
// Reset: rst_n clears all valid bits, both counters and the sequencer at once.
// ----------------------------------------------------------------------------
module arp_address_cache #(
    parameter int ENTRIES = aac_pkg::AAC_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [aac_pkg::IP_W-1:0]    ip_key,
    input  logic [aac_pkg::MAC_W-1:0]   mac_in,
    output logic                        done,
    output logic                        found,
    output logic [aac_pkg::MAC_W-1:0]   mac_out,
    output logic [aac_pkg::SLOT_W-1:0]  slot_used,
    output logic                        add_dropped,
    output logic [aac_pkg::TOTAL_W-1:0] hit_total,
    output logic [aac_pkg::TOTAL_W-1:0] miss_total
);
    import aac_pkg::*;

    // Index width of the entry store; a single entry still gets one bit.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Read port: the sequencer walks the entries in index order, and the
    // store answers in the next cycle with the valid bit, address and MAC.
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_valid;
    logic [IP_W-1:0]  rd_ip;
    logic [MAC_W-1:0] rd_mac;

    // Write port: used at most once per add item, in the finishing step, after the
    // full scan has settled which slot (lowest match, else lowest free) wins.
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IP_W-1:0]  wr_ip;
    logic [MAC_W-1:0] wr_mac;

    // The sequencer owns the item registers, the compare unit, the hit and
    // miss counters and the result registers.
    aac_scan_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_scan_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .ip_key      (ip_key),
        .mac_in      (mac_in),
        .done        (done),
        .found       (found),
        .mac_out     (mac_out),
        .slot_used   (slot_used),
        .add_dropped (add_dropped),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .rd_en       (rd_en),
        .rd_idx      (rd_idx),
        .rd_valid    (rd_valid),
        .rd_ip       (rd_ip),
        .rd_mac      (rd_mac),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_ip       (wr_ip),
        .wr_mac      (wr_mac)
    );

    // Entry storage: valid flags in flip-flops, address and MAC in memory.
    // Address and MAC of an entry are only used once its valid bit is set.
    aac_entry_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_entry_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_valid (rd_valid),
        .rd_ip    (rd_ip),
        .rd_mac   (rd_mac),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_ip    (wr_ip),
        .wr_mac   (wr_mac)
    );

endmodule

// ===== src/aac_entry_store.sv =====
// ----------------------------------------------------------------------------
// aac_entry_store: entry storage for the ARP address cache
// Valid bits in flip-flops cleared by reset; address and MAC in a memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module aac_entry_store #(
    parameter int ENTRIES = aac_pkg::AAC_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_idx,
    output logic                     rd_valid,
    output logic [aac_pkg::IP_W-1:0] rd_ip,
    output logic [aac_pkg::MAC_W-1:0] rd_mac,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_idx,
    input  logic [aac_pkg::IP_W-1:0] wr_ip,
    input  logic [aac_pkg::MAC_W-1:0] wr_mac
);
    import aac_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [IP_W-1:0]    ip_mem  [ENTRIES];
    logic [MAC_W-1:0]   mac_mem [ENTRIES];
    logic               rd_valid_reg;
    logic [IP_W-1:0]    rd_ip_reg;
    logic [MAC_W-1:0]   rd_mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ip_mem[wr_idx]  <= wr_ip;
            mac_mem[wr_idx] <= wr_mac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid_reg <= valid_reg[rd_idx];
            rd_ip_reg    <= ip_mem[rd_idx];
            rd_mac_reg   <= mac_mem[rd_idx];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_ip    = rd_ip_reg;
    assign rd_mac   = rd_mac_reg;

endmodule

// ===== src/aac_scan_ctrl.sv =====
// ----------------------------------------------------------------------------
// aac_scan_ctrl: sequencer and shared compare unit
// Walks the entries one per cycle, compares each against the key, records
// the lowest match and the lowest free slot, then updates state and results.
// ----------------------------------------------------------------------------
module aac_scan_ctrl #(
    parameter int ENTRIES = aac_pkg::AAC_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [aac_pkg::IP_W-1:0]    ip_key,
    input  logic [aac_pkg::MAC_W-1:0]   mac_in,
    output logic                        done,
    output logic                        found,
    output logic [aac_pkg::MAC_W-1:0]   mac_out,
    output logic [aac_pkg::SLOT_W-1:0]  slot_used,
    output logic                        add_dropped,
    output logic [aac_pkg::TOTAL_W-1:0] hit_total,
    output logic [aac_pkg::TOTAL_W-1:0] miss_total,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_idx,
    input  logic                        rd_valid,
    input  logic [aac_pkg::IP_W-1:0]    rd_ip,
    input  logic [aac_pkg::MAC_W-1:0]   rd_mac,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_idx,
    output logic [aac_pkg::IP_W-1:0]    wr_ip,
    output logic [aac_pkg::MAC_W-1:0]   wr_mac
);
    import aac_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    aac_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 func_reg;
    logic [IP_W-1:0]      key_reg;
    logic [MAC_W-1:0]     mac_reg;
    logic                 match_hit_reg;
    logic [IDX_W-1:0]     match_idx_reg;
    logic [MAC_W-1:0]     match_mac_reg;
    logic                 free_hit_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic [TOTAL_W-1:0]   hit_cnt_reg;
    logic [TOTAL_W-1:0]   miss_cnt_reg;
    logic                 done_reg;
    logic                 found_reg;
    logic [MAC_W-1:0]     mac_out_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 dropped_reg;

    logic                 scan_end;
    logic                 cmp_match;
    logic                 cmp_free;
    logic                 finish;
    logic                 accept;
    logic                 add_ok;
    logic [IDX_W-1:0]     sel_idx;
    logic [SLOT_W+IDX_W-1:0] sel_wide;

    assign scan_end  = (cnt_reg == CNT_W'(ENTRIES));
    assign accept    = start && (state_reg == ST_IDLE);
    assign finish    = (state_reg == ST_FINISH);

    // The shared compare unit: one entry per cycle against the latched key.
    assign cmp_match = pend_reg && rd_valid && (rd_ip == key_reg);
    assign cmp_free  = pend_reg && !rd_valid;

    assign add_ok    = match_hit_reg || free_hit_reg;
    assign sel_idx   = match_hit_reg ? match_idx_reg : free_idx_reg;
    assign sel_wide  = {{SLOT_W{1'b0}}, sel_idx};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy   = 1'b1;
        rd_en  = 1'b0;
        wr_en  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = !scan_end;
            end
            ST_FINISH:
            begin
                wr_en = (func_reg == FUNC_ADD) && add_ok;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign rd_idx = cnt_reg[IDX_W-1:0];
    assign wr_idx = sel_idx;
    assign wr_ip  = key_reg;
    assign wr_mac = mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            done_reg  <= finish;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (finish && (func_reg == FUNC_LOOKUP))
            begin
                if (match_hit_reg)
                begin
                    hit_cnt_reg <= hit_cnt_reg + TOTAL_W'(1);
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + TOTAL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cmp_idx_reg <= rd_idx;
        end
        if (accept)
        begin
            func_reg      <= func;
            key_reg       <= ip_key;
            mac_reg       <= mac_in;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
        end
        else
        begin
            if (cmp_match && !match_hit_reg)
            begin
                match_hit_reg <= 1'b1;
                match_idx_reg <= cmp_idx_reg;
                match_mac_reg <= rd_mac;
            end
            if (cmp_free && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (finish)
        begin
            if (func_reg == FUNC_LOOKUP)
            begin
                found_reg   <= match_hit_reg;
                mac_out_reg <= match_hit_reg ? match_mac_reg : '0;
                slot_reg    <= match_hit_reg ? sel_wide[SLOT_W-1:0] : '0;
                dropped_reg <= 1'b0;
            end
            else
            begin
                found_reg   <= 1'b0;
                mac_out_reg <= '0;
                slot_reg    <= add_ok ? sel_wide[SLOT_W-1:0] : '0;
                dropped_reg <= !add_ok;
            end
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign mac_out     = mac_out_reg;
    assign slot_used   = slot_reg;
    assign add_dropped = dropped_reg;
    assign hit_total   = hit_cnt_reg;
    assign miss_total  = miss_cnt_reg;

`ifndef SYNTHESIS
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without a finishing step");

    a_add_keeps_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (func_reg == FUNC_ADD)) |=> ($stable(hit_cnt_reg) && $stable(miss_cnt_reg)))
        else $error("add item changed a lookup counter");

    a_found_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found_reg && dropped_reg))
        else $error("result is both found and dropped");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");
`endif

endmodule
